// File: sv/ihex_pkg.sv
`timescale 1ns / 1ps

package ihex_pkg;

    localparam int CHAR_W   = 8;
    localparam int MSIZE_W  = 22;
    localparam int ADDR_W   = 21;
    localparam int DATA_W   = 8;
    localparam int KIND_W   = 2;
    localparam int CODE_W   = 3;
    localparam int SEG_W    = 20;
    localparam int OFFS_W   = 16;

    localparam logic [MSIZE_W-1:0] MEM_SIZE_RESET = 22'd65536;

    localparam logic [CHAR_W-1:0] CH_COLON   = 8'd58;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;

    localparam logic [7:0] REC_DATA    = 8'h00;
    localparam logic [7:0] REC_EOF     = 8'h01;
    localparam logic [7:0] REC_SEGMENT = 8'h02;
    localparam logic [7:0] REC_START   = 8'h03;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EOF   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    localparam logic [CODE_W-1:0] ERR_HEADER  = 3'd0;
    localparam logic [CODE_W-1:0] ERR_RANGE   = 3'd1;
    localparam logic [CODE_W-1:0] ERR_SHORT   = 3'd2;
    localparam logic [CODE_W-1:0] ERR_SEGMENT = 3'd3;
    localparam logic [CODE_W-1:0] ERR_TYPE    = 3'd4;

    typedef enum logic [4:0] {
        PH_LINE_START = 5'b00001,
        PH_SKIP       = 5'b00010,
        PH_HEADER     = 5'b00100,
        PH_DATA       = 5'b01000,
        PH_SEGMENT    = 5'b10000
    } phase_t;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [CODE_W-1:0] code;
    } res_t;

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_value(input logic [CHAR_W-1:0] c);
        logic [4:0] v;
        if (c >= 8'd48 && c <= 8'd57)
            v = 5'(c - 8'd48);
        else if (c >= 8'd65 && c <= 8'd70)
            v = 5'(c - 8'd55);
        else if (c >= 8'd97 && c <= 8'd102)
            v = 5'(c - 8'd87);
        else
            v = 5'd16;
        return v;
    endfunction

endpackage

// File: sv/intel_hex_record_loader_unit.sv
`timescale 1ns / 1ps
// Each character is registered in the input stage; its result word is registered in the output stage on m_axis.
// Throughput: one character per cycle; the parser core adds no stall of its own,
// so only a stalled m_axis holds back s_axis.
// Reset (rst_n, async, active low): parser waits for a line start, segment base
// and counters clear, mem_size returns to 65536, pipeline and output go empty.

module intel_hex_record_loader_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] character
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [20:0] write_address, [28:21] write_data, [31:29] error_code
    output logic [31:0]                     m_axis_tdata,
    output logic [1:0]                      m_axis_tuser,   // [1:0] result_kind
    input  logic                            cfg_wr_en,
    input  logic [ihex_pkg::MSIZE_W-1:0]    cfg_wr_data     // mem_size
);

    logic [ihex_pkg::MSIZE_W-1:0]   mem_size_reg;
    logic                           in_valid_reg;
    logic [ihex_pkg::CHAR_W-1:0]    in_char_reg;
    logic                           out_valid_reg, out_valid_next;
    ihex_pkg::res_t                 out_res_reg;

    logic                           advance;
    logic                           step;
    ihex_pkg::res_t                 core_res;
    logic                           core_halted;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign step          = in_valid_reg && advance;

    ihex_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .character (in_char_reg),
        .mem_size  (mem_size_reg),
        .res       (core_res),
        .halted    (core_halted)
    );

    always_comb
    begin
        if (advance)
            out_valid_next = step && core_res.valid;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_size_reg  <= ihex_pkg::MEM_SIZE_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                mem_size_reg <= cfg_wr_data;
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_char_reg <= s_axis_tdata;
        if (advance)
            out_res_reg <= core_res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tdata  = {out_res_reg.code, out_res_reg.data, out_res_reg.addr};

`ifndef SYNTH
    // once halted the parser must stay silent
    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        core_halted |-> !core_res.valid)
        else $error("result produced while halted");

    // an end-of-file or error word is always followed by the halted state
    a_stop_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != ihex_pkg::KIND_WRITE) |-> core_halted)
        else $error("stop word without halt");

    // empty output stage never blocks the input side
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
`endif

endmodule

// File: sv/ihex_core.sv
`timescale 1ns / 1ps

module ihex_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  logic [ihex_pkg::CHAR_W-1:0]       character,
    input  logic [ihex_pkg::MSIZE_W-1:0]      mem_size,
    output ihex_pkg::res_t                    res,
    output logic                              halted
);

    ihex_pkg::phase_t                 phase_reg,  phase_next;
    logic [2:0]                       digit_reg,  digit_next;
    logic [7:0]                       count_reg,  count_next;
    logic [ihex_pkg::OFFS_W-1:0]      offset_reg, offset_next;
    logic [ihex_pkg::SEG_W-1:0]       seg_reg,    seg_next;
    logic [ihex_pkg::ADDR_W-1:0]      addr_reg,   addr_next;
    logic [15:0]                      acc_reg,    acc_next;
    logic                             halted_reg, halted_next;

    logic [4:0]                       h;
    logic                             hex_ok;
    logic [15:0]                      acc_shift;
    logic [ihex_pkg::ADDR_W-1:0]      start;
    logic [ihex_pkg::MSIZE_W-1:0]     end_sum;

    assign h         = ihex_pkg::hex_value(character);
    assign hex_ok    = !h[4];
    assign acc_shift = {acc_reg[11:0], h[3:0]};
    assign start     = {1'b0, seg_reg} + {5'b0, offset_reg};
    assign end_sum   = {1'b0, start} + {14'b0, count_reg};
    assign halted    = halted_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        digit_next  = digit_reg;
        count_next  = count_reg;
        offset_next = offset_reg;
        seg_next    = seg_reg;
        addr_next   = addr_reg;
        acc_next    = acc_reg;
        halted_next = halted_reg;
        res         = '0;

        if (step && !halted_reg)
        begin
            unique case (phase_reg)
                ihex_pkg::PH_LINE_START:
                begin
                    if (character == ihex_pkg::CH_COLON)
                    begin
                        phase_next = ihex_pkg::PH_HEADER;
                        digit_next = 3'd0;
                        acc_next   = '0;
                    end
                    else if (character != ihex_pkg::CH_NEWLINE)
                    begin
                        phase_next = ihex_pkg::PH_SKIP;
                    end
                end
                ihex_pkg::PH_HEADER:
                begin
                    if (!hex_ok)
                    begin
                        halted_next = 1'b1;
                        res.valid   = 1'b1;
                        res.kind    = ihex_pkg::KIND_ERROR;
                        res.code    = ihex_pkg::ERR_HEADER;
                    end
                    else
                    begin
                        acc_next   = acc_shift;
                        digit_next = digit_reg + 3'd1;
                        if (digit_reg == 3'd1)
                        begin
                            count_next = acc_shift[7:0];
                            acc_next   = '0;
                        end
                        else if (digit_reg == 3'd5)
                        begin
                            offset_next = acc_shift;
                            acc_next    = '0;
                        end
                        else if (digit_reg == 3'd7)
                        begin
                            acc_next   = '0;
                            digit_next = 3'd0;
                            // record type is complete: dispatch on it now
                            unique case (acc_shift[7:0])
                                ihex_pkg::REC_DATA:
                                begin
                                    if (end_sum > mem_size)
                                    begin
                                        halted_next = 1'b1;
                                        res.valid   = 1'b1;
                                        res.kind    = ihex_pkg::KIND_ERROR;
                                        res.code    = ihex_pkg::ERR_RANGE;
                                    end
                                    else
                                    begin
                                        addr_next  = start;
                                        phase_next = (count_reg == 8'd0) ?
                                                     ihex_pkg::PH_SKIP : ihex_pkg::PH_DATA;
                                    end
                                end
                                ihex_pkg::REC_EOF:
                                begin
                                    halted_next = 1'b1;
                                    res.valid   = 1'b1;
                                    res.kind    = ihex_pkg::KIND_EOF;
                                end
                                ihex_pkg::REC_SEGMENT:
                                begin
                                    phase_next = ihex_pkg::PH_SEGMENT;
                                end
                                ihex_pkg::REC_START:
                                begin
                                    phase_next = ihex_pkg::PH_SKIP;
                                end
                                default:
                                begin
                                    halted_next = 1'b1;
                                    res.valid   = 1'b1;
                                    res.kind    = ihex_pkg::KIND_ERROR;
                                    res.code    = ihex_pkg::ERR_TYPE;
                                end
                            endcase
                        end
                    end
                end
                ihex_pkg::PH_DATA:
                begin
                    if (!hex_ok)
                    begin
                        halted_next = 1'b1;
                        res.valid   = 1'b1;
                        res.kind    = ihex_pkg::KIND_ERROR;
                        res.code    = ihex_pkg::ERR_SHORT;
                    end
                    else if (digit_reg == 3'd0)
                    begin
                        acc_next   = {12'b0, h[3:0]};
                        digit_next = 3'd1;
                    end
                    else
                    begin
                        res.valid  = 1'b1;
                        res.kind   = ihex_pkg::KIND_WRITE;
                        res.addr   = addr_reg;
                        res.data   = {acc_reg[3:0], h[3:0]};
                        acc_next   = '0;
                        digit_next = 3'd0;
                        addr_next  = addr_reg + 21'd1;
                        count_next = count_reg - 8'd1;
                        if (count_reg == 8'd1)
                            phase_next = ihex_pkg::PH_SKIP;
                    end
                end
                ihex_pkg::PH_SEGMENT:
                begin
                    if (!hex_ok)
                    begin
                        halted_next = 1'b1;
                        res.valid   = 1'b1;
                        res.kind    = ihex_pkg::KIND_ERROR;
                        res.code    = ihex_pkg::ERR_SEGMENT;
                    end
                    else if (digit_reg == 3'd3)
                    begin
                        seg_next   = {acc_shift, 4'b0};
                        acc_next   = '0;
                        digit_next = 3'd0;
                        phase_next = ihex_pkg::PH_SKIP;
                    end
                    else
                    begin
                        acc_next   = acc_shift;
                        digit_next = digit_reg + 3'd1;
                    end
                end
                ihex_pkg::PH_SKIP:
                begin
                    if (character == ihex_pkg::CH_NEWLINE)
                        phase_next = ihex_pkg::PH_LINE_START;
                end
                default:
                begin
                    phase_next = ihex_pkg::PH_LINE_START;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= ihex_pkg::PH_LINE_START;
            digit_reg  <= '0;
            count_reg  <= '0;
            offset_reg <= '0;
            seg_reg    <= '0;
            addr_reg   <= '0;
            acc_reg    <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            digit_reg  <= digit_next;
            count_reg  <= count_next;
            offset_reg <= offset_next;
            seg_reg    <= seg_next;
            addr_reg   <= addr_next;
            acc_reg    <= acc_next;
            halted_reg <= halted_next;
        end
    end

endmodule
